// ----- design/pse_pkg.sv -----
// ============================================================================
// pse_pkg
// Shared widths, command codes and status codes of the postfix evaluator.
// ============================================================================
package pse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W = $clog2(DATA_WIDTH);

  localparam int NUMBER_W = 32;
  localparam int TOP_W    = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int OUT_TDATA_W = ((TOP_W + STATUS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - TOP_W - STATUS_W;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_END  = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ARITH     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;

endpackage

// ----- design/postfix_stack_evaluator.sv -----
// ============================================================================
// postfix_stack_evaluator
// Integer postfix expression evaluator on a bounded operand stack.
// ============================================================================
// One token is taken per transfer on the s_ side. A push, or an operator
// with too few operands, leaves the input open for the next token. Add,
// subtract and multiply fetch both operands, compute and write back; divide
// fetches both operands, runs DATA_WIDTH steps of the restoring divider,
// fixes the sign and writes back; a divide by zero or of the most negative
// value by minus one ends after the fetch. An end token waits for the m_ side
// to take the previous result. The operand stack is a single-port-read memory,
// so the two operands of an operator are fetched in consecutive cycles. A
// result transfer on the m_ side is produced only by the end token; tokens
// that make no result can still be taken while a result waits on the m_ side.
module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [NUMBER_W-1:0]     s_tdata,   // [31:0] number
  input  logic [CMD_W-1:0]        s_tuser,   // [2:0] cmd
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_TDATA_W-1:0]  m_tdata    // [31:0] top_value, [34:32] status
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_EXEC, S_DIV, S_NEG, S_WRITE, S_END_OUT
  } state_t;

  localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [STATUS_W-1:0]     err;
  logic [CMD_W-1:0]        op;
  logic [DATA_WIDTH-1:0]   op_x;
  logic [DATA_WIDTH-1:0]   res;
  logic [DATA_WIDTH-1:0]   rem;
  logic [DATA_WIDTH-1:0]   quo;
  logic [DATA_WIDTH-1:0]   dvs;
  logic                    neg;
  logic [DIV_CNT_W-1:0]    div_cnt;

  logic [DATA_WIDTH-1:0]   mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0]   rdata;
  logic [ADDR_W-1:0]       raddr;
  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic [DATA_WIDTH-1:0]   wdata;

  logic                    accept;
  logic [DATA_WIDTH-1:0]   push_val;
  logic [DATA_WIDTH-1:0]   y_mag;
  logic [DATA_WIDTH-1:0]   x_mag;
  logic [DATA_WIDTH:0]     rem_sh;
  logic [DATA_WIDTH:0]     diff;
  logic                    full;
  logic                    short;
  logic [STATUS_W-1:0]     end_status;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign push_val = DATA_WIDTH'($signed(s_tdata));
  assign full     = (count >= CNT_W'(STACK_DEPTH));
  assign short    = (count < CNT_W'(2));

  assign raddr = (state == S_FETCH) ? ADDR_W'(count - CNT_W'(2))
                                    : ADDR_W'(count - CNT_W'(1));

  assign y_mag = rdata[DATA_WIDTH-1] ? (~rdata + DATA_WIDTH'(1)) : rdata;
  assign x_mag = op_x[DATA_WIDTH-1] ? (~op_x + DATA_WIDTH'(1)) : op_x;

  assign rem_sh = {rem[DATA_WIDTH-1:0], quo[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  assign end_status = (err != STAT_OK) ? err : STAT_EMPTY;

  always_comb begin
    we    = 1'b0;
    waddr = ADDR_W'(count);
    wdata = push_val;
    if (state == S_IDLE && accept && s_tuser == CMD_PUSH && !full) begin
      we = 1'b1;
    end else if (state == S_WRITE) begin
      we    = 1'b1;
      waddr = ADDR_W'(count - CNT_W'(2));
      wdata = res;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      err      <= STAT_OK;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_END_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= s_tuser;
            unique case (s_tuser)
              CMD_PUSH: begin
                if (full) begin
                  if (err == STAT_OK) err <= STAT_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                if (short) begin
                  if (err == STAT_OK) err <= STAT_UNDERFLOW;
                end else begin
                  state <= S_FETCH;
                end
              end
              CMD_END: state <= S_END_OUT;
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          op_x  <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          unique case (op)
            CMD_ADD: begin
              res   <= rdata + op_x;
              state <= S_WRITE;
            end
            CMD_SUB: begin
              res   <= rdata - op_x;
              state <= S_WRITE;
            end
            CMD_MUL: begin
              res   <= DATA_WIDTH'(rdata * op_x);
              state <= S_WRITE;
            end
            default: begin
              if (op_x == '0 || (rdata == DMIN && op_x == '1)) begin
                if (err == STAT_OK) err <= STAT_ARITH;
                state <= S_IDLE;
              end else begin
                rem     <= '0;
                quo     <= y_mag;
                dvs     <= x_mag;
                neg     <= rdata[DATA_WIDTH-1] ^ op_x[DATA_WIDTH-1];
                div_cnt <= DIV_CNT_W'(DATA_WIDTH - 1);
                state   <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          if (!diff[DATA_WIDTH]) begin
            rem <= diff[DATA_WIDTH-1:0];
            quo <= {quo[DATA_WIDTH-2:0], 1'b1};
          end else begin
            rem <= rem_sh[DATA_WIDTH-1:0];
            quo <= {quo[DATA_WIDTH-2:0], 1'b0};
          end
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == '0) begin
            state <= S_NEG;
          end
        end
        S_NEG: begin
          res   <= neg ? (~quo + DATA_WIDTH'(1)) : quo;
          state <= S_WRITE;
        end
        S_WRITE: begin
          count <= count - CNT_W'(1);
          state <= S_IDLE;
        end
        S_END_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (count == '0) begin
              m_tdata <= {{OUT_PAD_W{1'b0}}, end_status, {TOP_W{1'b0}}};
            end else begin
              m_tdata <= {{OUT_PAD_W{1'b0}}, err, TOP_W'(rdata)};
            end
            err   <= STAT_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/pse_checker.sv -----
// ============================================================================
// pse_checker
// Port-level checks of the postfix evaluator, bound to the top level.
// ============================================================================
module pse_checker
  import pse_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic [NUMBER_W-1:0]     s_tdata,
  input logic [CMD_W-1:0]        s_tuser,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [OUT_TDATA_W-1:0]  m_tdata
);

  // A result waiting on the output holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Status codes above the empty-stack code are never reported.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[TOP_W+STATUS_W-1:TOP_W] == STAT_OK ||
                  m_tdata[TOP_W+STATUS_W-1:TOP_W] == STAT_UNDERFLOW ||
                  m_tdata[TOP_W+STATUS_W-1:TOP_W] == STAT_FULL ||
                  m_tdata[TOP_W+STATUS_W-1:TOP_W] == STAT_ARITH ||
                  m_tdata[TOP_W+STATUS_W-1:TOP_W] == STAT_EMPTY))
    else $error("status out of range");

  // An empty-stack report carries a zero top value.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[TOP_W+STATUS_W-1:TOP_W] == STAT_EMPTY
      |-> m_tdata[TOP_W-1:0] == '0)
    else $error("empty report with nonzero top");

  // The end token keeps the input closed while its result is formed.
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_END |=> !s_tready)
    else $error("input open right after end token");

  // No result is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);

// ----- tb/sv/tb.sv -----
// ============================================================================
// tb
// Self-checking testbench for the postfix stack evaluator. Tokens go in on
// the s_ stream in random bursts, and end-of-expression results are taken
// from the m_ stream under a stall pattern of its own. Each accepted token
// is run through a local model of the operand stack and the sticky error.
// Every result is compared, field by field, with the oldest predicted one.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  localparam int TOTAL_TOKENS = 1700;
  localparam int DRAIN_EVERY  = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINUS_ONE = '1;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [NUMBER_W-1:0] number;
    logic                hold;
  } token_t;

  typedef struct packed {
    logic [TOP_W-1:0]    top;
    logic [STATUS_W-1:0] status;
  } answer_t;

  typedef enum logic [1:0] {
    ALWAYS_READY,
    COIN_FLIP,
    MOSTLY_STALLED,
    HARD_STALL
  } stall_mode_e;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [NUMBER_W-1:0]    s_tdata = '0;   // [31:0] number
  logic [CMD_W-1:0]       s_tuser = '0;   // [2:0] cmd
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [31:0] top_value, [34:32] status

  token_t  token_queue[$];
  answer_t expected_answers[$];

  logic [DATA_WIDTH-1:0] stack_model[STACK_DEPTH];
  int unsigned           depth_model = 0;
  logic [STATUS_W-1:0]   sticky_status = STAT_OK;

  int          est_depth = 0;
  int          tokens_queued = 0;
  bit          drain_next = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_e ready_mode = ALWAYS_READY;
  int          ready_left = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  postfix_stack_evaluator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  task automatic flag_error(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void latch_error(logic [STATUS_W-1:0] code);
    if (sticky_status == STAT_OK) begin
      sticky_status = code;
    end
  endfunction

  function automatic void evaluate_token(logic [CMD_W-1:0] cmd, logic [NUMBER_W-1:0] number);
    logic [DATA_WIDTH-1:0] x;
    logic [DATA_WIDTH-1:0] y;
    logic [DATA_WIDTH-1:0] r;
    answer_t               ans;
    bit                    ok;
    ok = 1'b1;
    r = '0;
    if (cmd == CMD_PUSH) begin
      if (depth_model >= STACK_DEPTH) begin
        latch_error(STAT_FULL);
      end else begin
        stack_model[ADDR_W'(depth_model)] = number;
        depth_model++;
      end
    end else if (cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_MUL || cmd == CMD_DIV) begin
      if (depth_model < 2) begin
        latch_error(STAT_UNDERFLOW);
      end else begin
        x = stack_model[ADDR_W'(depth_model - 1)];
        y = stack_model[ADDR_W'(depth_model - 2)];
        case (cmd)
          CMD_ADD: r = y + x;
          CMD_SUB: r = y - x;
          CMD_MUL: r = y * x;
          default: begin
            if (x == '0 || (y == MOST_NEG && x == MINUS_ONE)) begin
              ok = 1'b0;
            end else begin
              r = $signed(y) / $signed(x);
            end
          end
        endcase
        if (!ok) begin
          latch_error(STAT_ARITH);
        end else begin
          stack_model[ADDR_W'(depth_model - 2)] = r;
          depth_model--;
        end
      end
    end else if (cmd == CMD_END) begin
      ans.top = '0;
      ans.status = sticky_status;
      if (depth_model == 0) begin
        if (sticky_status == STAT_OK) begin
          ans.status = STAT_EMPTY;
        end
      end else begin
        ans.top = stack_model[ADDR_W'(depth_model - 1)];
      end
      expected_answers.push_back(ans);
      sticky_status = STAT_OK;
    end
  endfunction

  task automatic queue_token(logic [CMD_W-1:0] cmd, logic [NUMBER_W-1:0] number);
    token_t tok;
    tok.cmd = cmd;
    tok.number = number;
    tok.hold = drain_next;
    drain_next = 1'b0;
    token_queue.push_back(tok);
    if (cmd <= CMD_END) begin
      tokens_queued++;
    end
    if (cmd == CMD_PUSH) begin
      if (est_depth < STACK_DEPTH) begin
        est_depth++;
      end
    end else if (cmd != CMD_END && cmd <= CMD_DIV && est_depth >= 2) begin
      est_depth--;
    end
  endtask

  function automatic logic [NUMBER_W-1:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return MINUS_ONE;
      3, 4, 5: return $urandom_range(0, 8) - 32'd4;
      6:       return $urandom_range(0, 65535);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return CMD_ADD;
      1:       return CMD_SUB;
      2:       return CMD_MUL;
      default: return CMD_DIV;
    endcase
  endfunction

  always @(posedge clk) begin : drive_tokens
    token_t tok;
    logic   nxt_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        evaluate_token(s_tuser, s_tdata);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (token_queue.size() > 0 &&
                     !(token_queue[0].hold && expected_answers.size() > 0)) begin
          tok = token_queue.pop_front();
          s_tdata <= tok.number;
          s_tuser <= tok.cmd;
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_mode = stall_mode_e'($urandom_range(0, 3));
        ready_left = $urandom_range(4, 60);
      end else begin
        ready_left--;
      end
      case (ready_mode)
        ALWAYS_READY:   m_tready <= 1'b1;
        COIN_FLIP:      m_tready <= ($urandom_range(0, 1) == 1);
        MOSTLY_STALLED: m_tready <= ($urandom_range(0, 4) == 0);
        default:        m_tready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : check_answers
    answer_t             want;
    logic [TOP_W-1:0]    got_top;
    logic [STATUS_W-1:0] got_status;
    if (!rst && m_tvalid && m_tready) begin
      got_top = m_tdata[TOP_W-1:0];
      got_status = m_tdata[TOP_W +: STATUS_W];
      if (expected_answers.size() == 0) begin
        flag_error($sformatf("unexpected result: top_value %0d status %0d",
                             $signed(got_top), got_status));
      end else begin
        want = expected_answers.pop_front();
        if (got_top !== want.top) begin
          flag_error($sformatf("top_value %0d, expected %0d",
                               $signed(got_top), $signed(want.top)));
        end
        if (got_status !== want.status) begin
          flag_error($sformatf("status %0d, expected %0d", got_status, want.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int next_drain_at;
    int roll;
    int len;
    next_drain_at = DRAIN_EVERY;

    // Directed tokens: empty stack, underflow, wraparound, arithmetic errors,
    // truncating division and the unused command codes.
    queue_token(CMD_END, '0);
    queue_token(CMD_ADD, '0);
    queue_token(CMD_END, '1);
    queue_token(CMD_PUSH, MOST_POS);
    queue_token(CMD_PUSH, 32'd1);
    queue_token(CMD_ADD, '0);
    queue_token(CMD_END, '0);
    queue_token(CMD_PUSH, MINUS_ONE);
    queue_token(CMD_DIV, '0);
    queue_token(CMD_PUSH, '0);
    queue_token(CMD_DIV, '0);
    queue_token(3'd6, '1);
    queue_token(3'd7, MOST_NEG);
    queue_token(CMD_END, '0);
    queue_token(CMD_PUSH, -32'sd7);
    queue_token(CMD_PUSH, 32'd2);
    queue_token(CMD_DIV, '0);
    queue_token(CMD_PUSH, 32'd5);
    queue_token(CMD_SUB, '0);
    queue_token(CMD_PUSH, -32'sd3);
    queue_token(CMD_MUL, '0);
    queue_token(CMD_END, '0);
    queue_token(CMD_PUSH, MOST_NEG);
    queue_token(CMD_PUSH, 32'd1);
    queue_token(CMD_SUB, '0);
    queue_token(CMD_END, '0);
    drain_next = 1'b1;

    while (tokens_queued < TOTAL_TOKENS) begin
      if (tokens_queued >= next_drain_at) begin
        drain_next = 1'b1;
        next_drain_at += DRAIN_EVERY;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        // Overfill the stack, report, fold some of it back down and report again.
        repeat (STACK_DEPTH - est_depth + $urandom_range(1, 3)) begin
          queue_token(CMD_PUSH, pick_operand());
        end
        queue_token(CMD_END, $urandom());
        repeat ($urandom_range(10, STACK_DEPTH)) begin
          queue_token(pick_operator(), $urandom());
        end
        queue_token(CMD_END, $urandom());
      end else if (roll < 17) begin
        repeat ($urandom_range(1, 6)) begin
          queue_token(CMD_W'($urandom_range(0, 7)), $urandom());
        end
      end else begin
        len = $urandom_range(1, 10);
        repeat (len) begin
          if (est_depth < 2 || $urandom_range(0, 9) < 4) begin
            queue_token(CMD_PUSH, pick_operand());
          end else begin
            queue_token(pick_operator(), $urandom());
          end
        end
        queue_token(CMD_END, $urandom());
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (token_queue.size() != 0 || s_tvalid || expected_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
